### rtl/ssymm_pkg.sv
// Shared types, constants and helper functions for the symmetric matrix multiply unit.
// Used by the fpu, datapath, controller and top modules of the block; has no dependencies of its own.
package ssymm_pkg;

    localparam int MAX_DIM   = 16;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = $clog2(MAX_DIM) + 1;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int FP_W      = 32;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W = 40;

    localparam logic [FP_W-1:0] FP_ONE   = 32'h3F80_0000;
    localparam logic [FP_W-1:0] FP_QNAN  = 32'hFFC0_0000;
    localparam logic [FP_W-1:0] FP_QUIET = 32'h0040_0000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_RIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_N     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA       = 3'd5;

    typedef enum logic [1:0] {
        ACT_WR_A = 2'd0,
        ACT_WR_B = 2'd1,
        ACT_WR_C = 2'd2,
        ACT_READ = 2'd3
    } action_t;

    // fpu operand selection; also implies the operation
    typedef enum logic [2:0] {
        FS_C_BETA,
        FS_A_B,
        FS_SUM_TMP,
        FS_ALPHA_SUM,
        FS_ACC_TMP
    } fsel_t;

    typedef enum logic [1:0] {
        FD_NONE,
        FD_TMP,
        FD_SUM,
        FD_ACC
    } fdst_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CRD,
        S_CSCALE,
        S_CWAIT,
        S_PREP,
        S_KRD,
        S_KMUL,
        S_KMW,
        S_KADD,
        S_KAW,
        S_TMUL,
        S_TMW,
        S_TADD,
        S_TAW,
        S_FIN
    } state_t;

    typedef struct packed {
        logic  item_take;
        logic  acc_zero;
        logic  acc_c;
        logic  fpu_start;
        fsel_t fsel;
        fdst_t fdst;
        logic  sum_clr;
        logic  k_clr;
        logic  k_inc;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic req_ok;
        logic beta_zero;
        logic beta_one;
        logic alpha_zero;
        logic kmax_zero;
        logic k_last;
        logic fpu_done;
    } stat_t;

    function automatic logic [5:0] clz48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    function automatic logic [4:0] clz28(input logic [27:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) n = 5'(27 - i);
        end
        return n;
    endfunction

endpackage

### rtl/ssymm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssymm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/ssymm_fpu.sv
// Two-stage single precision multiply / add unit, round to nearest even, full denormals.
// Depends on ssymm_pkg. Result and done follow start through the stage 1 and stage 2 registers.
module ssymm_fpu (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     is_add,
    input  logic [ssymm_pkg::FP_W-1:0] a,
    input  logic [ssymm_pkg::FP_W-1:0] b,
    output logic                     done,
    output logic [ssymm_pkg::FP_W-1:0] res
);
    import ssymm_pkg::*;

    logic v1_reg, v2_reg;
    logic add_reg;
    logic spec_reg;
    logic [FP_W-1:0] spec_val_reg;
    logic sign_reg;
    logic zsign_reg;
    logic [47:0] p_reg;
    logic signed [11:0] me_reg;
    logic [27:0] sum_reg;
    logic [7:0] ae_reg;
    logic [FP_W-1:0] res_reg;

    // operand unpack
    logic [7:0] ea, eb, eae, ebe;
    logic [23:0] ma, mb;
    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    always_comb
    begin
        ea = a[30:23];
        eb = b[30:23];
        eae = (ea == 8'd0) ? 8'd1 : ea;
        ebe = (eb == 8'd0) ? 8'd1 : eb;
        ma = {ea != 8'd0, a[22:0]};
        mb = {eb != 8'd0, b[22:0]};
        a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
    end

    // stage 1 next values
    logic spec_next;
    logic [FP_W-1:0] spec_val_next;
    logic sign_next, zsign_next;
    logic [47:0] p_next;
    logic signed [11:0] me_next;
    logic [27:0] sum_next;
    logic [7:0] ae_next;
    logic swap;
    logic [7:0] eb_big, eb_sml, d;
    logic [23:0] m_big, m_sml;
    logic s_big, s_sml;
    logic [26:0] sml27, sml_sh;
    logic sml_st;

    always_comb
    begin
        p_next = ma * mb;
        me_next = $signed({4'd0, eae}) + $signed({4'd0, ebe}) - 12'sd127;

        swap = (b[30:0] > a[30:0]);
        eb_big = swap ? ebe : eae;
        eb_sml = swap ? eae : ebe;
        m_big = swap ? mb : ma;
        m_sml = swap ? ma : mb;
        s_big = swap ? b[31] : a[31];
        s_sml = swap ? a[31] : b[31];
        d = eb_big - eb_sml;
        sml27 = {m_sml, 3'd0};
        if (d >= 8'd27)
        begin
            sml_sh = {26'd0, m_sml != 24'd0};
        end
        else
        begin
            sml_st = |(sml27 & ~({27{1'b1}} << d[4:0]));
            sml_sh = (sml27 >> d[4:0]) | {26'd0, sml_st};
        end
        sml_st = 1'b0;
        if (s_big ^ s_sml)
        begin
            sum_next = {1'b0, m_big, 3'd0} - {1'b0, sml_sh};
        end
        else
        begin
            sum_next = {1'b0, m_big, 3'd0} + {1'b0, sml_sh};
        end
        ae_next = eb_big;
        zsign_next = a[31] & b[31];
        sign_next = is_add ? s_big : (a[31] ^ b[31]);

        spec_next = 1'b1;
        priority if (a_nan)
        begin
            spec_val_next = a | FP_QUIET;
        end
        else if (b_nan)
        begin
            spec_val_next = b | FP_QUIET;
        end
        else if (is_add && a_inf && b_inf && (a[31] != b[31]))
        begin
            spec_val_next = FP_QNAN;
        end
        else if (!is_add && ((a_inf && b_zero) || (b_inf && a_zero)))
        begin
            spec_val_next = FP_QNAN;
        end
        else if (is_add && a_inf)
        begin
            spec_val_next = a;
        end
        else if (is_add && b_inf)
        begin
            spec_val_next = b;
        end
        else if (!is_add && (a_inf || b_inf))
        begin
            spec_val_next = {a[31] ^ b[31], 8'hFF, 23'd0};
        end
        else
        begin
            spec_next = 1'b0;
            spec_val_next = FP_QNAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            add_reg <= is_add;
            spec_reg <= spec_next;
            spec_val_reg <= spec_val_next;
            sign_reg <= sign_next;
            zsign_reg <= zsign_next;
            p_reg <= p_next;
            me_reg <= me_next;
            sum_reg <= sum_next;
            ae_reg <= ae_next;
        end
    end

    // stage 2: normalize and round
    logic [5:0] mlz;
    logic signed [11:0] me_e, m_nsh;
    logic [47:0] mq;
    logic [7:0] mex;
    logic m_ovf, m_st;
    logic [FP_W-1:0] mul_res;
    logic [4:0] alz;
    logic signed [9:0] a_e;
    logic [27:0] aq;
    logic [7:0] aex;
    logic [FP_W-1:0] add_res;
    logic inc;

    always_comb
    begin
        mlz = clz48(p_reg);
        me_e = me_reg + 12'sd1 - $signed({6'd0, mlz});
        m_nsh = -me_reg;
        m_ovf = 1'b0;
        mex = 8'd0;
        mq = 48'd0;
        m_st = 1'b0;
        if (me_e >= 12'sd255)
        begin
            m_ovf = 1'b1;
        end
        else if (me_e >= 12'sd1)
        begin
            mq = p_reg << mlz;
            mex = me_e[7:0];
        end
        else if (!me_reg[11])
        begin
            mq = p_reg << me_reg[5:0];
        end
        else if (m_nsh >= 12'sd48)
        begin
            mq = {47'd0, 1'b1};
        end
        else
        begin
            m_st = |(p_reg & ~({48{1'b1}} << m_nsh[5:0]));
            mq = (p_reg >> m_nsh[5:0]) | {47'd0, m_st};
        end
        inc = mq[23] & ((|mq[22:0]) | mq[24]);
        if (p_reg == 48'd0)
        begin
            mul_res = {sign_reg, 31'd0};
        end
        else if (m_ovf)
        begin
            mul_res = {sign_reg, 8'hFF, 23'd0};
        end
        else
        begin
            mul_res = {sign_reg, {mex, mq[46:24]} + {30'd0, inc}};
        end

        alz = clz28(sum_reg);
        a_e = $signed({2'd0, ae_reg}) + 10'sd1 - $signed({5'd0, alz});
        aex = 8'd0;
        if (a_e >= 10'sd1)
        begin
            aq = sum_reg << alz;
            aex = a_e[7:0];
        end
        else
        begin
            aq = sum_reg << ae_reg[4:0];
        end
        if (sum_reg == 28'd0)
        begin
            add_res = {zsign_reg, 31'd0};
        end
        else if (a_e >= 10'sd255)
        begin
            add_res = {sign_reg, 8'hFF, 23'd0};
        end
        else
        begin
            add_res = {sign_reg, {aex, aq[26:4]}
                       + {30'd0, aq[3] & ((|aq[2:0]) | aq[4])}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            res_reg <= spec_reg ? spec_val_reg : (add_reg ? add_res : mul_res);
        end
    end

    assign done = v2_reg;
    assign res = res_reg;

endmodule

### rtl/ssymm_datapath.sv
// Datapath: configuration registers, A/B/C stores, accumulators, fpu and output register.
// Depends on ssymm_pkg, ssymm_ram and ssymm_fpu; steered by ssymm_ctrl.
module ssymm_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ssymm_pkg::cmd_t                 cmd,
    output ssymm_pkg::stat_t                st,
    input  logic [1:0]                      in_tuser,
    input  logic [ssymm_pkg::IN_DATA_W-1:0] in_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssymm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    output logic [ssymm_pkg::IN_DATA_W-1:0] out_tdata,
    output logic                            out_tuser
);
    import ssymm_pkg::*;

    logic side_reg, upper_reg;
    logic [DIM_W-1:0] rows_reg, cols_reg;
    logic [FP_W-1:0] alpha_reg, beta_reg;
    logic [IDX_W-1:0] row_reg, col_reg;
    logic ok_reg;
    logic [DIM_W-1:0] k_reg;
    logic [FP_W-1:0] acc_reg, sum_reg, tmp_reg;
    logic [IN_DATA_W-1:0] out_data_reg;
    logic out_range_reg;

    logic [IDX_W-1:0] in_row, in_col;
    logic [FP_W-1:0] in_value;
    logic [DIM_W-1:0] m_eff, n_eff, kmax;
    logic [IDX_W-1:0] kk, a_r, a_c;
    logic a_direct;
    logic [ADDR_W-1:0] a_addr, b_addr, w_addr;
    logic [FP_W-1:0] a_rdata, b_rdata, c_rdata;
    logic we_a, we_b, we_c;
    logic [FP_W-1:0] f_a, f_b, f_res;
    logic f_add, f_done;

    assign in_row = in_tdata[IDX_W-1:0];
    assign in_col = in_tdata[2*IDX_W-1:IDX_W];
    assign in_value = in_tdata[2*IDX_W+FP_W-1:2*IDX_W];
    assign w_addr = {in_col, in_row};
    assign cfg_ready = 1'b1;

    always_comb
    begin
        m_eff = (rows_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_reg;
        n_eff = (cols_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_reg;
        kmax = side_reg ? n_eff : m_eff;
        kk = k_reg[IDX_W-1:0];
        // left: A(row,k) B(k,col); right: B(row,k) A(k,col)
        a_r = side_reg ? kk : row_reg;
        a_c = side_reg ? col_reg : kk;
        b_addr = side_reg ? {kk, row_reg} : {col_reg, kk};
        a_direct = upper_reg ? (a_r <= a_c) : (a_r >= a_c);
        a_addr = a_direct ? {a_c, a_r} : {a_r, a_c};
        we_a = cmd.item_take && (action_t'(in_tuser) == ACT_WR_A);
        we_b = cmd.item_take && (action_t'(in_tuser) == ACT_WR_B);
        we_c = cmd.item_take && (action_t'(in_tuser) == ACT_WR_C);

        st.is_read = (action_t'(in_tuser) == ACT_READ);
        st.req_ok = ({1'b0, in_row} < m_eff) && ({1'b0, in_col} < n_eff);
        st.beta_zero = (beta_reg[30:0] == 31'd0);
        st.beta_one = (beta_reg == FP_ONE);
        st.alpha_zero = (alpha_reg[30:0] == 31'd0);
        st.kmax_zero = (kmax == '0);
        st.k_last = ((k_reg + DIM_W'(1)) == kmax);
        st.fpu_done = f_done;

        unique case (cmd.fsel)
            FS_C_BETA:    begin f_a = c_rdata;   f_b = beta_reg; f_add = 1'b0; end
            FS_A_B:
            begin
                f_a = side_reg ? b_rdata : a_rdata;
                f_b = side_reg ? a_rdata : b_rdata;
                f_add = 1'b0;
            end
            FS_SUM_TMP:   begin f_a = sum_reg;   f_b = tmp_reg;  f_add = 1'b1; end
            FS_ALPHA_SUM: begin f_a = alpha_reg; f_b = sum_reg;  f_add = 1'b0; end
            FS_ACC_TMP:   begin f_a = acc_reg;   f_b = tmp_reg;  f_add = 1'b1; end
            default:      begin f_a = acc_reg;   f_b = tmp_reg;  f_add = 1'b1; end
        endcase
    end

    ssymm_ram #(.WIDTH(FP_W), .DEPTH(DEPTH)) u_a_ram (
        .clk(clk), .we(we_a), .waddr(w_addr), .wdata(in_value),
        .raddr(a_addr), .rdata(a_rdata)
    );

    ssymm_ram #(.WIDTH(FP_W), .DEPTH(DEPTH)) u_b_ram (
        .clk(clk), .we(we_b), .waddr(w_addr), .wdata(in_value),
        .raddr(b_addr), .rdata(b_rdata)
    );

    ssymm_ram #(.WIDTH(FP_W), .DEPTH(DEPTH)) u_c_ram (
        .clk(clk), .we(we_c), .waddr(w_addr), .wdata(in_value),
        .raddr({col_reg, row_reg}), .rdata(c_rdata)
    );

    ssymm_fpu u_fpu (
        .clk(clk), .rst_n(rst_n), .start(cmd.fpu_start), .is_add(f_add),
        .a(f_a), .b(f_b), .done(f_done), .res(f_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= 1'b0;
            upper_reg <= 1'b1;
            rows_reg <= '0;
            cols_reg <= '0;
            alpha_reg <= FP_ONE;
            beta_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SIDE_RIGHT: side_reg <= cfg_data[0];
                CFG_UPPER:      upper_reg <= cfg_data[0];
                CFG_ROWS_M:     rows_reg <= cfg_data[DIM_W-1:0];
                CFG_COLS_N:     cols_reg <= cfg_data[DIM_W-1:0];
                CFG_ALPHA:      alpha_reg <= cfg_data;
                CFG_BETA:       beta_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_take)
        begin
            row_reg <= in_row;
            col_reg <= in_col;
            ok_reg <= st.req_ok;
        end
        if (cmd.k_clr)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + DIM_W'(1);
        end
        if (cmd.acc_zero)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_c)
        begin
            acc_reg <= c_rdata;
        end
        else if (f_done && (cmd.fdst == FD_ACC))
        begin
            acc_reg <= f_res;
        end
        if (cmd.sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (f_done && (cmd.fdst == FD_SUM))
        begin
            sum_reg <= f_res;
        end
        if (f_done && (cmd.fdst == FD_TMP))
        begin
            tmp_reg <= f_res;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {(ok_reg ? acc_reg : {FP_W{1'b0}}), col_reg, row_reg};
            out_range_reg <= ok_reg;
        end
    end

    assign out_tdata = out_data_reg;
    assign out_tuser = out_range_reg;

endmodule

### rtl/ssymm_ctrl.sv
// Controller: input/output handshakes and the sequencing of one result read.
// Depends on ssymm_pkg; drives ssymm_datapath through cmd_t and reads stat_t.
module ssymm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  ssymm_pkg::stat_t st,
    output ssymm_pkg::cmd_t  cmd
);
    import ssymm_pkg::*;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic take;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign take = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && st.is_read)
                begin
                    state_next = st.req_ok ? S_CRD : S_FIN;
                end
            end
            S_CRD:    state_next = S_CSCALE;
            S_CSCALE: state_next = (st.beta_zero || st.beta_one) ? S_PREP : S_CWAIT;
            S_CWAIT:  if (st.fpu_done) state_next = S_PREP;
            S_PREP:
            begin
                priority if (st.alpha_zero) state_next = S_FIN;
                else if (st.kmax_zero)      state_next = S_TMUL;
                else                        state_next = S_KRD;
            end
            S_KRD:    state_next = S_KMUL;
            S_KMUL:   state_next = S_KMW;
            S_KMW:    if (st.fpu_done) state_next = S_KADD;
            S_KADD:   state_next = S_KAW;
            S_KAW:    if (st.fpu_done) state_next = st.k_last ? S_TMUL : S_KRD;
            S_TMUL:   state_next = S_TMW;
            S_TMW:    if (st.fpu_done) state_next = S_TADD;
            S_TADD:   state_next = S_TAW;
            S_TAW:    if (st.fpu_done) state_next = S_FIN;
            S_FIN:    if (!out_valid_reg || m_axis_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.fsel = FS_C_BETA;
        cmd.fdst = FD_NONE;
        cmd.item_take = take;
        unique case (state_reg)
            S_CSCALE:
            begin
                cmd.acc_zero = st.beta_zero;
                cmd.acc_c = !st.beta_zero && st.beta_one;
                cmd.fpu_start = !st.beta_zero && !st.beta_one;
            end
            S_CWAIT: cmd.fdst = FD_ACC;
            S_PREP:
            begin
                cmd.sum_clr = 1'b1;
                cmd.k_clr = 1'b1;
            end
            S_KMUL:
            begin
                cmd.fpu_start = 1'b1;
                cmd.fsel = FS_A_B;
            end
            S_KMW:   cmd.fdst = FD_TMP;
            S_KADD:
            begin
                cmd.fpu_start = 1'b1;
                cmd.fsel = FS_SUM_TMP;
            end
            S_KAW:
            begin
                cmd.fdst = FD_SUM;
                cmd.k_inc = st.fpu_done;
            end
            S_TMUL:
            begin
                cmd.fpu_start = 1'b1;
                cmd.fsel = FS_ALPHA_SUM;
            end
            S_TMW:   cmd.fdst = FD_TMP;
            S_TADD:
            begin
                cmd.fpu_start = 1'b1;
                cmd.fsel = FS_ACC_TMP;
            end
            S_TAW:   cmd.fdst = FD_ACC;
            S_FIN:   cmd.out_load = !out_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a new result never overwrites one still waiting to be taken
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("output register overwritten");

    a_oor_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (take && st.is_read && !st.req_ok) |=> (state_reg == S_FIN))
        else $error("out of range read did not go straight to output");

    a_fpu_lat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fpu_start |=> !st.fpu_done)
        else $error("fpu done one cycle after start");

endmodule

### rtl/symmetric_matrix_multiply_fp32_unit.sv
// Usage
//   Input stream (s_axis_*): tuser carries the action (write A, write B, write C,
//   read result); tdata carries row, col and the single precision value. Writes
//   land in the stores in the cycle of the transfer, one item per cycle while no read runs.
//   A read produces one result on m_axis_*: tdata = out_row, out_col, result;
//   tuser = in_range. Out of range reads return result 0 with in_range 0.
//   Config port (cfg_*): index 0..5 = side_right, upper_triangle, rows_m,
//   cols_n, alpha_bits, beta_bits; write only while the block is idle.
// Read sequence
//   A read scales C by beta through the fpu when beta is neither 0 nor 1, then
//   runs K steps; K is rows_m (left side) or cols_n (right side), clamped to 16;
//   each step of K is a store read, a multiply and an add through the one shared
//   two-stage fpu. With alpha zero the sum is skipped. An out of range read goes
//   straight to the output register. No new item is taken while a read runs.
// Reset
//   rst_n clears control state and loads register defaults (alpha 1.0,
//   upper triangle). Store contents are undefined until written.
// Stall
//   One output register holds the result; the block accepts the next item while
//   it waits, and a following read stalls only at its last step.
// Depends on ssymm_pkg, ssymm_ctrl and ssymm_datapath.
module symmetric_matrix_multiply_fp32_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ssymm_pkg::IN_DATA_W-1:0] s_axis_tdata,  // row, col, value
    input  logic [1:0]                      s_axis_tuser,  // action
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ssymm_pkg::IN_DATA_W-1:0] m_axis_tdata,  // out_row, out_col, result
    output logic                            m_axis_tuser,  // in_range
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssymm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);
    import ssymm_pkg::*;

    cmd_t  cmd;
    stat_t st;

    ssymm_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .st(st),
        .cmd(cmd)
    );

    ssymm_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .st(st),
        .in_tuser(s_axis_tuser),
        .in_tdata(s_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .out_tdata(m_axis_tdata),
        .out_tuser(m_axis_tuser)
    );

endmodule

### tb/symmetric_matrix_multiply_fp32_unit_tb.sv
// Testbench for symmetric_matrix_multiply_fp32_unit: loads A, B and C, reads result
// entries under several register settings and checks them against an IEEE-754 predictor.
// Depends on ssymm_pkg and the unit RTL.
`timescale 1ns / 100ps

module symmetric_matrix_multiply_fp32_unit_tb;
    import ssymm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] result;
        logic        in_range;
    } entry_t;

    typedef struct {
        action_t     act;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        bit          typed;
        logic [31:0] exp_result;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // row, col, value
    logic [1:0]  s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // out_row, out_col, result
    logic        m_axis_tuser;   // in_range
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // predictor state
    logic [31:0] a_mem [DEPTH];
    logic [31:0] b_mem [DEPTH];
    logic [31:0] c_mem [DEPTH];
    logic        p_side_right;
    logic        p_upper;
    logic [4:0]  p_rows_m;
    logic [4:0]  p_cols_n;
    logic [31:0] p_alpha;
    logic [31:0] p_beta;

    entry_t      pending_entries [$];
    int          fail_count;
    int          cycles;
    int          tready_hold;
    bit          calm;

    symmetric_matrix_multiply_fp32_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- IEEE single precision helpers ----------------
    function automatic bit fp_is_nan(logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] != 0;
    endfunction

    function automatic bit fp_is_inf(logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] == 0;
    endfunction

    function automatic bit fp_is_zero(logic [31:0] f);
        return f[30:0] == 0;
    endfunction

    // exact widening of a non-NaN single to double
    function automatic real fp_to_real(logic [31:0] f);
        logic [23:0] man;
        int          e;
        man = {1'b0, f[22:0]};
        if (f[30:23] == 8'hFF)
            return $bitstoreal({f[31], 11'h7FF, 52'h0});
        if (fp_is_zero(f))
            return $bitstoreal({f[31], 63'h0});
        if (f[30:23] == 0)
        begin
            e = -126;
            while (!man[23])
            begin
                man = man << 1;
                e--;
            end
            return $bitstoreal({f[31], 11'(e + 1023), man[22:0], 29'h0});
        end
        e = int'(f[30:23]) - 127;
        return $bitstoreal({f[31], 11'(e + 1023), f[22:0], 29'h0});
    endfunction

    // round a double to single, nearest-even, with subnormals and overflow
    function automatic logic [31:0] real_to_fp(real x);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        int          fe;
        int          sh;
        d = $realtobits(x);
        if (d[62:52] == 11'h7FF)
            return {d[63], 8'hFF, 23'h0};
        if (d[62:52] == 0)
            return {d[63], 31'h0};
        fe = int'(d[62:52]) - 1023 + 127;
        if (fe >= 255)
            return {d[63], 8'hFF, 23'h0};
        sig = {11'h0, 1'b1, d[51:0]};
        sh = (fe >= 1) ? 29 : 30 - fe;
        if (sh > 60)
            sh = 60;
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0]))
            kept++;
        if (fe >= 1)
        begin
            if (kept[24])
            begin
                kept = kept >> 1;
                fe++;
            end
            if (fe >= 255)
                return {d[63], 8'hFF, 23'h0};
            return {d[63], fe[7:0], kept[22:0]};
        end
        return {d[63], 8'(kept >> 23), kept[22:0]};
    endfunction

    // products of two singles are exact in double; sums round safely twice
    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        if (fp_is_nan(a))
            return a | FP_QUIET;
        if (fp_is_nan(b))
            return b | FP_QUIET;
        if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b)))
            return FP_QNAN;
        return real_to_fp(fp_to_real(a) * fp_to_real(b));
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        if (fp_is_nan(a))
            return a | FP_QUIET;
        if (fp_is_nan(b))
            return b | FP_QUIET;
        if (fp_is_inf(a) && fp_is_inf(b) && a[31] != b[31])
            return FP_QNAN;
        return real_to_fp(fp_to_real(a) + fp_to_real(b));
    endfunction

    // ---------------- predictor ----------------
    function automatic int mem_addr(logic [3:0] r, logic [3:0] c);
        return int'(r) + int'(c) * MAX_DIM;
    endfunction

    function automatic logic [31:0] sym_a(logic [3:0] r, logic [3:0] c);
        bit direct;
        direct = p_upper ? (r <= c) : (r >= c);
        return direct ? a_mem[mem_addr(r, c)] : a_mem[mem_addr(c, r)];
    endfunction

    function automatic int dim_used(logic [4:0] d);
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    function automatic entry_t predict_entry(logic [3:0] r, logic [3:0] c);
        entry_t      e;
        logic [31:0] acc;
        logic [31:0] sum;
        logic [31:0] prod;
        int          kmax;
        e.row      = r;
        e.col      = c;
        e.result   = '0;
        e.in_range = (r < dim_used(p_rows_m)) && (c < dim_used(p_cols_n));
        if (!e.in_range)
            return e;
        if (fp_is_zero(p_beta))
            acc = '0;
        else if (p_beta == FP_ONE)
            acc = c_mem[mem_addr(r, c)];
        else
            acc = fp_mul(c_mem[mem_addr(r, c)], p_beta);
        // NaN alpha compares unequal to zero, so the product still runs
        if (!fp_is_zero(p_alpha))
        begin
            sum  = '0;
            kmax = p_side_right ? dim_used(p_cols_n) : dim_used(p_rows_m);
            for (int k = 0; k < kmax; k++)
            begin
                if (p_side_right)
                    prod = fp_mul(b_mem[mem_addr(r, 4'(k))], sym_a(4'(k), c));
                else
                    prod = fp_mul(sym_a(r, 4'(k)), b_mem[mem_addr(4'(k), c)]);
                sum = fp_add(sum, prod);
            end
            acc = fp_add(acc, fp_mul(p_alpha, sum));
        end
        e.result = acc;
        return e;
    endfunction

    function automatic logic [31:0] rand_fp();
        logic [31:0] specials [8];
        specials = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0001, 32'h0000_0001, 32'h7F7F_FFFF, 32'hBF80_0000};
        case ($urandom % 8)
            0: return $urandom;
            1: return specials[$urandom % 8];
            default: return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
        endcase
    endfunction

    // ---------------- drivers ----------------
    task automatic send_item(action_t act, logic [3:0] r, logic [3:0] c, logic [31:0] v,
                             bit typed, logic [31:0] typed_result);
        entry_t e;
        if (!calm && $urandom % 6 == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {v, c, r};
        do @(posedge clk); while (!s_axis_tready);
        if (act == ACT_READ)
        begin
            e = predict_entry(r, c);
            if (typed)
            begin
                e.result   = typed_result;
                e.in_range = 1'b0;
            end
            pending_entries.push_back(e);
        end
        else
        begin
            case (act)
                ACT_WR_A: a_mem[mem_addr(r, c)] = v;
                ACT_WR_B: b_mem[mem_addr(r, c)] = v;
                default:  c_mem[mem_addr(r, c)] = v;
            endcase
        end
    endtask

    // cfg_valid stays high across back to back writes; the caller drops it
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SIDE_RIGHT: p_side_right = val[0];
            CFG_UPPER:      p_upper      = val[0];
            CFG_ROWS_M:     p_rows_m     = val[4:0];
            CFG_COLS_N:     p_cols_n     = val[4:0];
            CFG_ALPHA:      p_alpha      = val;
            default:        p_beta       = val;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        fail_count++;
    endtask

    // ---------------- result checking ----------------
    always @(posedge clk)
    begin
        entry_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_entries.size() == 0)
                report_mismatch("unexpected transfer", m_axis_tdata[39:8], 32'h0);
            else
            begin
                want = pending_entries.pop_front();
                if (m_axis_tdata[3:0] != want.row)
                    report_mismatch("out_row", 32'(m_axis_tdata[3:0]), 32'(want.row));
                if (m_axis_tdata[7:4] != want.col)
                    report_mismatch("out_col", 32'(m_axis_tdata[7:4]), 32'(want.col));
                if (m_axis_tdata[39:8] != want.result)
                    report_mismatch("result", m_axis_tdata[39:8], want.result);
                if (m_axis_tuser != want.in_range)
                    report_mismatch("in_range", 32'(m_axis_tuser), 32'(want.in_range));
            end
        end
    end

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (tready_hold > 0)
        begin
            tready_hold--;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom % 12 == 0)
        begin
            tready_hold = $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    stim_row_t directed [] = '{
        '{ACT_WR_A, 4'd0,  4'd0,  32'h0000_0000, 1'b0, 32'h0},
        '{ACT_WR_A, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{ACT_WR_B, 4'd0,  4'd15, 32'h7F80_0000, 1'b0, 32'h0},
        '{ACT_WR_B, 4'd15, 4'd0,  32'h0000_0001, 1'b0, 32'h0},
        '{ACT_WR_C, 4'd15, 4'd0,  32'h8000_0000, 1'b0, 32'h0},
        '{ACT_WR_C, 4'd15, 4'd15, 32'h7F7F_FFFF, 1'b0, 32'h0},
        '{ACT_WR_A, 4'd7,  4'd9,  32'h3F80_0000, 1'b0, 32'h0},
        '{ACT_WR_B, 4'd9,  4'd7,  32'hAAAA_5555, 1'b0, 32'h0},
        '{ACT_WR_C, 4'd10, 4'd5,  32'h5555_AAAA, 1'b0, 32'h0},
        // nothing is in range right after reset
        '{ACT_READ, 4'd0,  4'd0,  32'h0000_0000, 1'b1, 32'h0},
        '{ACT_READ, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'h0},
        '{ACT_READ, 4'd15, 4'd0,  32'h1234_5678, 1'b1, 32'h0},
        '{ACT_READ, 4'd0,  4'd15, 32'h0000_0000, 1'b1, 32'h0}
    };

    // side, upper, rows, cols, alpha, beta; all-ones alpha/beta means pick at random
    logic [31:0] settings [9][6] = '{
        '{0, 1, 16, 16, 32'h3F80_0000, 32'h0000_0000},
        '{1, 0, 16, 16, 32'h4020_0000, 32'h3F80_0000},
        '{0, 0, 5,  3,  32'h0000_0000, 32'hBFC0_0000},
        '{1, 1, 7,  16, 32'h8000_0000, 32'h7FC0_0000},
        '{0, 1, 0,  9,  32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{1, 0, 16, 0,  32'hFFFF_FFFF, 32'h8000_0000},
        '{0, 0, 1,  1,  32'hC000_0000, 32'h4000_0000},
        '{1, 1, 3,  11, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{0, 1, 16, 16, 32'hFFFF_FFFF, 32'hFFFF_FFFF}
    };

    initial
    begin
        logic [3:0] r;
        logic [3:0] c;
        int         m;
        int         n;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        fail_count    = 0;
        cycles        = 0;
        tready_hold   = 0;
        calm          = 1'b0;
        p_side_right  = 1'b0;
        p_upper       = 1'b1;
        p_rows_m      = '0;
        p_cols_n      = '0;
        p_alpha       = FP_ONE;
        p_beta        = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i].act, directed[i].row, directed[i].col, directed[i].value,
                      directed[i].typed, directed[i].exp_result);
        drain();

        // load every entry so that no read touches an unwritten word
        for (int i = 0; i < DEPTH; i++)
        begin
            send_item(ACT_WR_A, 4'(i), 4'(i >> 4), rand_fp(), 1'b0, 32'h0);
            send_item(ACT_WR_B, 4'(i), 4'(i >> 4), rand_fp(), 1'b0, 32'h0);
            send_item(ACT_WR_C, 4'(i), 4'(i >> 4), rand_fp(), 1'b0, 32'h0);
        end
        drain();

        for (int p = 0; p < 9; p++)
        begin
            calm = (p == 8);
            write_reg(CFG_SIDE_RIGHT, settings[p][0]);
            write_reg(CFG_UPPER, settings[p][1]);
            write_reg(CFG_ROWS_M, settings[p][2]);
            write_reg(CFG_COLS_N, settings[p][3]);
            write_reg(CFG_ALPHA, (settings[p][4] == 32'hFFFF_FFFF) ? rand_fp() : settings[p][4]);
            write_reg(CFG_BETA, (settings[p][5] == 32'hFFFF_FFFF) ? rand_fp() : settings[p][5]);
            cfg_valid <= 1'b0;
            m = dim_used(p_rows_m);
            n = dim_used(p_cols_n);
            for (int i = 0; i < 62; i++)
            begin
                if ($urandom % 100 < 45)
                begin
                    r = (m > 0 && $urandom % 5 != 0) ? 4'($urandom_range(0, m - 1)) : 4'($urandom);
                    c = (n > 0 && $urandom % 5 != 0) ? 4'($urandom_range(0, n - 1)) : 4'($urandom);
                    send_item(ACT_READ, r, c, $urandom, 1'b0, 32'h0);
                end
                else
                    send_item(action_t'($urandom_range(0, 2)), 4'($urandom), 4'($urandom),
                              rand_fp(), 1'b0, 32'h0);
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending_entries.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/ssymm_pkg.sv
rtl/ssymm_ram.sv
rtl/ssymm_fpu.sv
rtl/ssymm_datapath.sv
rtl/ssymm_ctrl.sv
rtl/symmetric_matrix_multiply_fp32_unit.sv
tb/symmetric_matrix_multiply_fp32_unit_tb.sv
